// ===== hdl/dpn_pkg.sv =====
// Shared types, widths and codes for the discrete posterior normaliser.
`timescale 1ns / 1ps
package dpn_pkg;

    localparam int PROB_W        = 17;
    localparam int SUM_W         = 23;
    localparam int IDX_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int MAX_LEAVES_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_LIKE  = 2'd1,
        STS_NO_EVID  = 2'd2,
        STS_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_ERR,
        ST_M_READ,
        ST_M_MUL,
        ST_M_DIV,
        ST_M_WAIT,
        ST_SUMCHK,
        ST_P_READ,
        ST_P_START,
        ST_P_WAIT,
        ST_P_OUT
    } t_state;

    typedef struct packed {
        logic load;          // input word accepted
        logic clear_run;     // run state back to zero
        logic idx_clr;
        logic idx_inc;
        logic pair_rd;
        logic mul_en;
        logic div_start;
        logic div_post;      // 1: posterior division, 0: mass division
        logic mass_wr;
        logic mass_rd;
        logic out_load_post;
        logic out_load_err;
    } t_dp_cmd;

    typedef struct packed {
        logic overflow;
        logic max_zero;
        logic sum_zero;
        logic idx_last;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/dpn_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dpn_div #(
    parameter int DVD_W = 34
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DVD_W-1:0]            i_dividend,
    input  logic [dpn_pkg::SUM_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [DVD_W-1:0]            o_quotient
);
    import dpn_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1))
                    r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits back in SUM_W bits
            r_rem <= fits ? SUM_W'(trial - {1'b0, r_dvs}) : trial[SUM_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/dpn_datapath.sv =====
// Leaf stores, multiplier, shared divider, run registers and output register.
`timescale 1ns / 1ps
module dpn_datapath #(
    parameter int MAX_LEAVES = dpn_pkg::MAX_LEAVES_DEF,
    parameter int FRAC_BITS  = dpn_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dpn_pkg::t_dp_cmd               i_cmd,
    output dpn_pkg::t_dp_sts               o_sts,
    input  logic [dpn_pkg::PROB_W-1:0]     i_prior_prob,
    input  logic [dpn_pkg::PROB_W-1:0]     i_likelihood,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [dpn_pkg::IDX_W-1:0]      o_leaf_index,
    output logic [dpn_pkg::PROB_W-1:0]     o_posterior_prob,
    output logic [dpn_pkg::PROB_W-1:0]     o_scaled_mass,
    output logic [dpn_pkg::SUM_W-1:0]      o_evidence_mass,
    output logic [dpn_pkg::PROB_W-1:0]     o_peak_likelihood,
    output logic [dpn_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_last_result
);
    import dpn_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEAVES + 1);
    localparam int ADR_W = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
    localparam int PRD_W = 2 * PROB_W;
    localparam int DVD_W = (PRD_W > PROB_W + FRAC_BITS) ? PRD_W : PROB_W + FRAC_BITS;

    // run state
    logic [CNT_W-1:0]  r_count;
    logic [PROB_W-1:0] r_max;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovf;
    logic [ADR_W-1:0]  r_idx;

    // stores
    logic [PRD_W-1:0]  pair_mem [MAX_LEAVES];
    logic [PROB_W-1:0] mass_mem [MAX_LEAVES];
    logic [PRD_W-1:0]  r_pair_rd;
    logic [PROB_W-1:0] r_mass_rd;
    logic [PRD_W-1:0]  r_prod;

    // divider
    logic [DVD_W-1:0]  div_dividend;
    logic [SUM_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DVD_W-1:0]  div_quo;
    logic [PROB_W-1:0] quo_sat;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic              count_full;
    t_status           err_status;

    // output register
    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_idx;
    logic [PROB_W-1:0] r_o_post;
    logic [PROB_W-1:0] r_o_mass;
    logic [SUM_W-1:0]  r_o_sum;
    logic [PROB_W-1:0] r_o_scale;
    t_status           r_o_status;
    logic              r_o_last;

    assign count_full = (r_count >= CNT_W'(MAX_LEAVES));
    assign quo_sat    = (|div_quo[DVD_W-1:PROB_W]) ? {PROB_W{1'b1}} : div_quo[PROB_W-1:0];
    assign sum_wide   = {1'b0, r_sum} + (SUM_W + 1)'(quo_sat);
    assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_comb begin
        if (r_ovf)
            err_status = STS_OVERFLOW;
        else if (r_max == '0)
            err_status = STS_NO_LIKE;
        else
            err_status = STS_NO_EVID;
    end

    always_comb begin
        if (i_cmd.div_post) begin
            div_dividend = DVD_W'({r_mass_rd, {FRAC_BITS{1'b0}}});
            div_divisor  = r_sum;
        end else begin
            div_dividend = DVD_W'(r_prod);
            div_divisor  = SUM_W'(r_max);
        end
    end

    dpn_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // run registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clear_run) begin
                r_count <= '0;
                r_max   <= '0;
                r_sum   <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.load) begin
                if (count_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                    if (i_likelihood > r_max)
                        r_max <= i_likelihood;
                end
            end
            if (i_cmd.mass_wr)
                r_sum <= sum_sat;
            if (i_cmd.idx_clr || i_cmd.clear_run)
                r_idx <= '0;
            else if (i_cmd.idx_inc)
                r_idx <= r_idx + ADR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !count_full)
            pair_mem[r_count[ADR_W-1:0]] <= {i_prior_prob, i_likelihood};
        if (i_cmd.pair_rd)
            r_pair_rd <= pair_mem[r_idx];
        if (i_cmd.mul_en)
            r_prod <= r_pair_rd[PRD_W-1:PROB_W] * r_pair_rd[PROB_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mass_wr)
            mass_mem[r_idx] <= quo_sat;
        if (i_cmd.mass_rd)
            r_mass_rd <= mass_mem[r_idx];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (i_cmd.out_load_post || i_cmd.out_load_err)
            r_o_valid <= 1'b1;
        else if (i_ready)
            r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_post) begin
            r_o_idx    <= IDX_W'(r_idx);
            r_o_post   <= quo_sat;
            r_o_mass   <= r_mass_rd;
            r_o_sum    <= r_sum;
            r_o_scale  <= r_max;
            r_o_status <= STS_OK;
            r_o_last   <= o_sts.idx_last;
        end else if (i_cmd.out_load_err) begin
            r_o_idx    <= '0;
            r_o_post   <= '0;
            r_o_mass   <= '0;
            r_o_sum    <= '0;
            r_o_scale  <= r_max;
            r_o_status <= err_status;
            r_o_last   <= 1'b1;
        end
    end

    assign o_sts.overflow = r_ovf;
    assign o_sts.max_zero = (r_max == '0);
    assign o_sts.sum_zero = (r_sum == '0);
    assign o_sts.idx_last = (CNT_W'(r_idx) + CNT_W'(1) == r_count);
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_o_valid || i_ready;

    assign o_valid            = r_o_valid;
    assign o_leaf_index       = r_o_idx;
    assign o_posterior_prob   = r_o_post;
    assign o_scaled_mass      = r_o_mass;
    assign o_evidence_mass    = r_o_sum;
    assign o_peak_likelihood  = r_o_scale;
    assign o_status           = r_o_status;
    assign o_last_result      = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEAVES))
        else $error("leaf count beyond store depth");

    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mass_wr |=> r_sum >= $past(r_sum))
        else $error("evidence sum shrank while accumulating");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load_post || i_cmd.out_load_err) |=> r_o_valid)
        else $error("output register load lost");

endmodule

// ===== hdl/dpn_ctrl.sv =====
// Sequencer for loading, mass pass, posterior pass and error words.
`timescale 1ns / 1ps
module dpn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_leaf,
    output logic              o_ready,
    output dpn_pkg::t_dp_cmd  o_cmd,
    input  dpn_pkg::t_dp_sts  i_sts
);
    import dpn_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_LOAD;
        else
            r_state <= n_state;
    end

    assign o_ready = (r_state == ST_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_leaf)
                        n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.overflow || i_sts.max_zero) begin
                    n_state = ST_ERR;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_M_READ;
                end
            end
            ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_err = 1'b1;
                    o_cmd.clear_run    = 1'b1;
                    n_state            = ST_LOAD;
                end
            end
            ST_M_READ: begin
                o_cmd.pair_rd = 1'b1;
                n_state       = ST_M_MUL;
            end
            ST_M_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_M_DIV;
            end
            ST_M_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_M_WAIT;
            end
            ST_M_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.mass_wr = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = ST_SUMCHK;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_M_READ;
                    end
                end
            end
            ST_SUMCHK: begin
                if (i_sts.sum_zero) begin
                    n_state = ST_ERR;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_P_READ;
                end
            end
            ST_P_READ: begin
                o_cmd.mass_rd = 1'b1;
                n_state       = ST_P_START;
            end
            ST_P_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_post  = 1'b1;
                n_state         = ST_P_WAIT;
            end
            ST_P_WAIT: begin
                if (i_sts.div_done)
                    n_state = ST_P_OUT;
            end
            ST_P_OUT: begin
                // quotient holds in the divider until the output register frees
                if (i_sts.out_free) begin
                    o_cmd.out_load_post = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clear_run = 1'b1;
                        n_state         = ST_LOAD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_P_READ;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load_post || o_cmd.out_load_err) |-> i_sts.out_free)
        else $error("output register overwritten");

    a_stop_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_last_leaf) |=> !o_ready)
        else $error("input taken after marked leaf");

endmodule

// ===== hdl/discrete_posterior_normalizer_core.sv =====
// Discrete posterior normaliser: top level joining sequencer and datapath.
//
// Input channel (i_valid / o_ready): one word per leaf, prior and likelihood in
// unsigned Q1.16; i_last_leaf marks the final leaf and starts the computation.
// Leaves load at one per cycle. After the marked leaf o_ready stays low until
// the whole set has been answered.
// Output channel (o_valid / i_ready): one word per leaf in load order with the
// posterior, scaled mass, evidence sum and scale; o_last_result marks the end.
// An error (all likelihoods zero, zero evidence, too many leaves) gives a
// single word carrying its status instead.
// A serial divider of D = max(34, 17 + FRAC_BITS) steps is shared by both
// passes. Per leaf, the mass pass reads the pair, multiplies prior by
// likelihood, divides by the peak likelihood and adds the mass to the sum;
// the posterior pass divides the stored mass by the sum and loads the output.
// The output register lets the next word be computed while one waits; when the
// receiver stalls, the sequencer holds with the finished quotient.
// Reset (synchronous, active low) clears the run state and the output valid;
// the leaf stores need no clearing.
`timescale 1ns / 1ps
module discrete_posterior_normalizer_core #(
    parameter int MAX_LEAVES = dpn_pkg::MAX_LEAVES_DEF,
    parameter int FRAC_BITS  = dpn_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dpn_pkg::PROB_W-1:0]     i_prior_prob,
    input  logic [dpn_pkg::PROB_W-1:0]     i_likelihood,
    input  logic                           i_last_leaf,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dpn_pkg::IDX_W-1:0]      o_leaf_index,
    output logic [dpn_pkg::PROB_W-1:0]     o_posterior_prob,
    output logic [dpn_pkg::PROB_W-1:0]     o_scaled_mass,
    output logic [dpn_pkg::SUM_W-1:0]      o_evidence_mass,
    output logic [dpn_pkg::PROB_W-1:0]     o_peak_likelihood,
    output logic [dpn_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_last_result
);
    import dpn_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dpn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_leaf (i_last_leaf),
        .o_ready     (o_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dpn_datapath #(
        .MAX_LEAVES (MAX_LEAVES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_prior_prob       (i_prior_prob),
        .i_likelihood       (i_likelihood),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_leaf_index       (o_leaf_index),
        .o_posterior_prob   (o_posterior_prob),
        .o_scaled_mass      (o_scaled_mass),
        .o_evidence_mass    (o_evidence_mass),
        .o_peak_likelihood  (o_peak_likelihood),
        .o_status           (o_status),
        .o_last_result      (o_last_result)
    );

endmodule

// ===== test/tb_discrete_posterior_normalizer_core.sv =====
// Self-checking testbench for the discrete posterior normaliser core.
`timescale 1ns / 1ps
module tb_discrete_posterior_normalizer_core;

    import dpn_pkg::*;

    localparam int LEAVES_MAX   = MAX_LEAVES_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int RANDOM_LEAVES = 352;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [PROB_W-1:0] PROB_SAT = '1;
    localparam logic [SUM_W-1:0]  SUM_SAT  = '1;
    localparam logic [PROB_W-1:0] ONE      = 17'd65536;

    typedef struct {
        logic [PROB_W-1:0] prior;
        logic [PROB_W-1:0] like;
        logic              last;
    } t_leaf;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [PROB_W-1:0] post;
        logic [PROB_W-1:0] mass;
        logic [SUM_W-1:0]  evid;
        logic [PROB_W-1:0] scale;
        t_status           status;
        logic              last;
    } t_posterior;

    typedef enum int {
        SET_PLAIN,
        SET_NO_LIKE,
        SET_NO_EVID,
        SET_TINY,
        SET_WIDE
    } t_set_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [PROB_W-1:0]    i_prior_prob = '0;
    logic [PROB_W-1:0]    i_likelihood = '0;
    logic                 i_last_leaf = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [IDX_W-1:0]     o_leaf_index;
    logic [PROB_W-1:0]    o_posterior_prob;
    logic [PROB_W-1:0]    o_scaled_mass;
    logic [SUM_W-1:0]     o_evidence_mass;
    logic [PROB_W-1:0]    o_peak_likelihood;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_last_result;

    discrete_posterior_normalizer_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_prior_prob       (i_prior_prob),
        .i_likelihood       (i_likelihood),
        .i_last_leaf        (i_last_leaf),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_leaf_index       (o_leaf_index),
        .o_posterior_prob   (o_posterior_prob),
        .o_scaled_mass      (o_scaled_mass),
        .o_evidence_mass    (o_evidence_mass),
        .o_peak_likelihood  (o_peak_likelihood),
        .o_status           (o_status),
        .o_last_result      (o_last_result)
    );

    t_leaf      leaf_pending[$];
    t_posterior posterior_q[$];

    // predictor copy of the run state
    logic [PROB_W-1:0] prior_mem [LEAVES_MAX];
    logic [PROB_W-1:0] like_mem  [LEAVES_MAX];
    logic [PROB_W-1:0] mass_mem  [LEAVES_MAX];
    int                leaf_cnt = 0;
    logic [PROB_W-1:0] peak_like = '0;
    logic              overflow_seen = 1'b0;

    int n_fail = 0;
    int leaves_in = 0;
    int sets_in = 0;
    int words_out = 0;
    int err_words = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_posterior posterior_word(input int idx, input logic [PROB_W-1:0] post,
                                                  input logic [PROB_W-1:0] mass,
                                                  input logic [SUM_W-1:0] evid,
                                                  input logic [PROB_W-1:0] scale,
                                                  input t_status status, input logic last);
        t_posterior w;
        w.idx    = idx[IDX_W-1:0];
        w.post   = post;
        w.mass   = mass;
        w.evid   = evid;
        w.scale  = scale;
        w.status = status;
        w.last   = last;
        return w;
    endfunction

    task automatic predict_posteriors(input logic [PROB_W-1:0] prior,
                                      input logic [PROB_W-1:0] like, input logic last);
        longint unsigned mass;
        longint unsigned acc;
        longint unsigned post;
        if (leaf_cnt < LEAVES_MAX) begin
            prior_mem[leaf_cnt] = prior;
            like_mem[leaf_cnt]  = like;
            leaf_cnt++;
            if (like > peak_like)
                peak_like = like;
        end else begin
            overflow_seen = 1'b1;
        end
        if (last) begin
            sets_in++;
            if (overflow_seen) begin
                posterior_q = {posterior_q,
                               posterior_word(0, '0, '0, '0, peak_like, STS_OVERFLOW, 1'b1)};
            end else if (peak_like == '0) begin
                posterior_q = {posterior_q,
                               posterior_word(0, '0, '0, '0, '0, STS_NO_LIKE, 1'b1)};
            end else begin
                acc = '0;
                for (int k = 0; k < leaf_cnt; k++) begin
                    mass = 64'(prior_mem[k]);
                    mass = mass * like_mem[k] / peak_like;
                    if (mass > PROB_SAT)
                        mass = 64'(PROB_SAT);
                    mass_mem[k] = mass[PROB_W-1:0];
                    acc = acc + mass;
                    if (acc > SUM_SAT)
                        acc = 64'(SUM_SAT);
                end
                if (acc == 0) begin
                    posterior_q = {posterior_q,
                                   posterior_word(0, '0, '0, '0, peak_like, STS_NO_EVID, 1'b1)};
                end else begin
                    for (int k = 0; k < leaf_cnt; k++) begin
                        post = 64'(mass_mem[k]);
                        post = (post << FRAC) / acc;
                        if (post > PROB_SAT)
                            post = 64'(PROB_SAT);
                        posterior_q = {posterior_q,
                                       posterior_word(k, post[PROB_W-1:0], mass_mem[k],
                                                      acc[SUM_W-1:0], peak_like, STS_OK,
                                                      k == leaf_cnt - 1)};
                    end
                end
            end
            leaf_cnt      = 0;
            peak_like     = '0;
            overflow_seen = 1'b0;
        end
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // driver: bursts of words with random gaps between them
    t_leaf nxt;
    int    burst_left = 0;
    int    gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_posteriors(i_prior_prob, i_likelihood, i_last_leaf);
                leaves_in++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (leaf_pending.size() != 0) begin
                    nxt = leaf_pending.pop_front();
                    i_prior_prob <= nxt.prior;
                    i_likelihood <= nxt.like;
                    i_last_leaf  <= nxt.last;
                    i_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: receiver stalls in short and long spells, with calm stretches
    int stall_left = 0;
    int phase_cnt = 0;
    logic calm = 1'b0;
    t_posterior want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                words_out++;
                if (o_status != STS_OK)
                    err_words++;
                if (posterior_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected word, expected none, actual idx %0d post %0d st %0d",
                             $time, o_leaf_index, o_posterior_prob, o_status);
                end else begin
                    want = posterior_q.pop_front();
                    check_field("leaf_index", 32'(want.idx), 32'(o_leaf_index));
                    check_field("posterior_prob", 32'(want.post), 32'(o_posterior_prob));
                    check_field("scaled_mass", 32'(want.mass), 32'(o_scaled_mass));
                    check_field("evidence_mass", 32'(want.evid), 32'(o_evidence_mass));
                    check_field("peak_likelihood", 32'(want.scale), 32'(o_peak_likelihood));
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("last_result", 32'(want.last), 32'(o_last_result));
                end
            end
            phase_cnt++;
            if (phase_cnt == 700) begin
                phase_cnt = 0;
                calm = ~calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 6);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_discrete_posterior_normalizer_core: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_leaf(input logic [PROB_W-1:0] prior, input logic [PROB_W-1:0] like,
                              input logic last);
        t_leaf w;
        w.prior = prior;
        w.like  = like;
        w.last  = last;
        leaf_pending = {leaf_pending, w};
    endtask

    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE;
            2:       return PROB_W'($urandom_range(0, 131071));
            3:       return PROB_W'($urandom_range(1, 255));
            default: return PROB_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic queue_set(input int n, input t_set_kind kind);
        logic [PROB_W-1:0] p;
        logic [PROB_W-1:0] l;
        for (int k = 0; k < n; k++) begin
            case (kind)
                SET_NO_LIKE: begin
                    p = rand_prob();
                    l = '0;
                end
                SET_NO_EVID: begin
                    p = '0;
                    l = rand_prob();
                end
                SET_TINY: begin
                    p = PROB_W'($urandom_range(0, 3));
                    l = PROB_W'($urandom_range(0, 3));
                end
                SET_WIDE: begin
                    p = PROB_W'($urandom_range(0, 131071));
                    l = PROB_W'($urandom_range(0, 131071));
                end
                default: begin
                    p = rand_prob();
                    l = rand_prob();
                end
            endcase
            queue_leaf(p, l, k == n - 1);
        end
    endtask

    initial begin : stim
        int        queued;
        int        set_no;
        int        n;
        int        pick;
        t_set_kind kind;

        // directed sets
        queue_leaf(ONE, ONE, 1'b1);                 // single leaf at full scale
        queue_leaf(17'd0, 17'd0, 1'b1);             // all likelihoods zero, one leaf
        queue_leaf(17'd40000, 17'd0, 1'b0);         // all likelihoods zero, several leaves
        queue_leaf(ONE, 17'd0, 1'b0);
        queue_leaf(PROB_SAT, 17'd0, 1'b1);
        queue_leaf(17'd0, ONE, 1'b0);               // zero priors: no evidence
        queue_leaf(17'd0, 17'd1, 1'b1);
        queue_leaf(17'd1, 17'd1, 1'b0);             // masses floor to zero
        queue_leaf(17'd0, 17'd2, 1'b1);
        queue_leaf(PROB_SAT, PROB_SAT, 1'b0);       // out-of-range values kept as they are
        queue_leaf(17'd1, 17'd0, 1'b0);
        queue_leaf(ONE, 17'd1, 1'b1);
        queue_leaf(17'd1, 17'd1, 1'b0);             // one tiny mass takes the whole posterior
        queue_leaf(17'd1, PROB_SAT, 1'b1);
        for (int k = 0; k < 4; k++)
            queue_leaf(17'd16384, 17'd32768, k == 3);
        queued = leaf_pending.size();

        // random sets; one full store and one overrun among them
        set_no = 0;
        while (set_no <= 14 || leaf_pending.size() < queued + RANDOM_LEAVES) begin
            pick = $urandom_range(0, 99);
            if (set_no == 6)
                n = LEAVES_MAX;
            else if (set_no == 14)
                n = LEAVES_MAX + $urandom_range(1, 3);
            else if (pick < 70)
                n = $urandom_range(1, 6);
            else if (pick < 95)
                n = $urandom_range(7, 20);
            else
                n = $urandom_range(21, 40);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                kind = SET_NO_LIKE;
            else if (pick < 10)
                kind = SET_NO_EVID;
            else if (pick < 15)
                kind = SET_TINY;
            else if (pick < 22)
                kind = SET_WIDE;
            else
                kind = SET_PLAIN;
            queue_set(n, kind);
            set_no++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (leaf_pending.size() != 0 || i_valid)
            @(posedge i_clk);
        while (posterior_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d leaf words in %0d sets, incl. a full store and an overrun;",
                 leaves_in, sets_in);
        $display("%0d result words checked, %0d of them error words.", words_out, err_words);
        if (n_fail == 0) begin
            $display("tb_discrete_posterior_normalizer_core: PASS");
        end else begin
            $display("tb_discrete_posterior_normalizer_core: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dpn_pkg.sv
hdl/dpn_div.sv
hdl/dpn_datapath.sv
hdl/dpn_ctrl.sv
hdl/discrete_posterior_normalizer_core.sv
test/tb_discrete_posterior_normalizer_core.sv
